// ===== hw/rtl/fbm_pkg.sv =====
`timescale 1ns / 1ps

package fbm_pkg;

  localparam int MAX_PATTERN_DEF   = 64;
  localparam int ALPHABET_DEF      = 256;
  localparam int MASK_BITS_DEF     = 32;
  localparam int POSITION_BITS_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int MATCH_W = 32;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  // Datapath operations issued by the sequencer
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CLR,
    OP_F_RD,
    OP_F_USE,
    OP_F_FIN,
    OP_B_RD,
    OP_B_USE,
    OP_RMW_RD,
    OP_RMW_WR,
    OP_BDONE,
    OP_E_RD0,
    OP_E_INIT,
    OP_E_RDW,
    OP_E_RDT,
    OP_E_UPD,
    OP_R_RD,
    OP_R_CMP,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic acc_build;
    logic acc_eval;
    logic clr_last;
    logic f_end;
    logic f_stop;
    logic m1_zero;
    logic b_done;
    logic m1_one;
    logic e_stop;
    logic r_done;
    logic out_wait;
  } st_t;

endpackage

// ===== hw/rtl/fbm_ctrl.sv =====
`timescale 1ns / 1ps

module fbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fbm_pkg::st_t  st,
  output fbm_pkg::cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_CLR    = 18'h00002,
    S_F_RD   = 18'h00004,
    S_F_USE  = 18'h00008,
    S_F_FIN  = 18'h00010,
    S_B_RD   = 18'h00020,
    S_B_USE  = 18'h00040,
    S_RMW_RD = 18'h00080,
    S_RMW_WR = 18'h00100,
    S_BDONE  = 18'h00200,
    S_E_RD0  = 18'h00400,
    S_E_INIT = 18'h00800,
    S_E_RDW  = 18'h01000,
    S_E_RDT  = 18'h02000,
    S_E_UPD  = 18'h04000,
    S_R_RD   = 18'h08000,
    S_R_CMP  = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.accept = (state_r == S_IDLE) && in_valid;

  always_comb begin
    case (state_r)
      S_IDLE:   cmd.op = fbm_pkg::OP_IDLE;
      S_CLR:    cmd.op = fbm_pkg::OP_CLR;
      S_F_RD:   cmd.op = fbm_pkg::OP_F_RD;
      S_F_USE:  cmd.op = fbm_pkg::OP_F_USE;
      S_F_FIN:  cmd.op = fbm_pkg::OP_F_FIN;
      S_B_RD:   cmd.op = fbm_pkg::OP_B_RD;
      S_B_USE:  cmd.op = fbm_pkg::OP_B_USE;
      S_RMW_RD: cmd.op = fbm_pkg::OP_RMW_RD;
      S_RMW_WR: cmd.op = fbm_pkg::OP_RMW_WR;
      S_BDONE:  cmd.op = fbm_pkg::OP_BDONE;
      S_E_RD0:  cmd.op = fbm_pkg::OP_E_RD0;
      S_E_INIT: cmd.op = fbm_pkg::OP_E_INIT;
      S_E_RDW:  cmd.op = fbm_pkg::OP_E_RDW;
      S_E_RDT:  cmd.op = fbm_pkg::OP_E_RDT;
      S_E_UPD:  cmd.op = fbm_pkg::OP_E_UPD;
      S_R_RD:   cmd.op = fbm_pkg::OP_R_RD;
      S_R_CMP:  cmd.op = fbm_pkg::OP_R_CMP;
      S_OUT:    cmd.op = fbm_pkg::OP_OUT;
      default:  cmd.op = fbm_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.acc_build) state_nxt = S_CLR;
          else if (st.acc_eval) state_nxt = S_E_RD0;
        end
      end
      S_CLR:    if (st.clr_last) state_nxt = S_F_RD;
      S_F_RD:   state_nxt = st.f_end ? S_F_FIN : S_F_USE;
      S_F_USE:  state_nxt = st.f_stop ? S_F_FIN : S_F_RD;
      S_F_FIN:  state_nxt = st.m1_zero ? S_BDONE : S_B_RD;
      S_B_RD:   state_nxt = S_B_USE;
      S_B_USE:  state_nxt = S_RMW_RD;
      S_RMW_RD: state_nxt = S_RMW_WR;
      S_RMW_WR: state_nxt = st.b_done ? S_BDONE : S_B_RD;
      S_BDONE:  state_nxt = S_IDLE;
      S_E_RD0:  state_nxt = S_E_INIT;
      S_E_INIT: state_nxt = st.m1_one ? S_R_RD : S_E_RDW;
      S_E_RDW:  state_nxt = S_E_RDT;
      S_E_RDT:  state_nxt = S_E_UPD;
      S_E_UPD:  state_nxt = st.e_stop ? S_R_RD : S_E_RDW;
      S_R_RD:   state_nxt = st.r_done ? S_OUT : S_R_CMP;
      S_R_CMP:  state_nxt = S_R_RD;
      S_OUT:    if (!st.out_wait) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/fbm_dp.sv =====
`timescale 1ns / 1ps

module fbm_dp #(
  parameter int MAX_PATTERN   = fbm_pkg::MAX_PATTERN_DEF,
  parameter int ALPHABET      = fbm_pkg::ALPHABET_DEF,
  parameter int MASK_BITS     = fbm_pkg::MASK_BITS_DEF,
  parameter int POSITION_BITS = fbm_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbm_pkg::cmd_t               cmd,
  output fbm_pkg::st_t                st,
  input  logic                        in_func,
  input  logic [fbm_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic                        in_is_last_pattern,
  input  logic                        in_is_first_text,
  input  logic                        in_is_last_text,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fbm_pkg::MATCH_W-1:0] out_match_position
);

  localparam int PLW    = $clog2(MAX_PATTERN + 1);
  localparam int PAW    = $clog2(MAX_PATTERN);
  localparam int WAW    = $clog2(MAX_PATTERN);
  localparam int WDEPTH = 1 << WAW;
  localparam int AW     = $clog2(ALPHABET);
  localparam int BDEPTH = ALPHABET * ALPHABET;
  localparam int BAW    = $clog2(BDEPTH);
  localparam int FCW    = $clog2(MASK_BITS);
  localparam int BW     = fbm_pkg::BYTE_W;

  localparam logic [FCW-1:0] F_LAST = FCW'(MASK_BITS - 2);

  // Character folding for table indexes
  logic [AW-1:0] fold_lut [1 << BW];
  for (genvar g = 0; g < (1 << BW); g++) begin : g_fold
    assign fold_lut[g] = AW'(g % ALPHABET);
  end

  function automatic logic [BAW-1:0] bidx(input logic [AW-1:0] fa, input logic [AW-1:0] fb);
    bidx = BAW'(BAW'(fa) * BAW'(ALPHABET) + BAW'(fb));
  endfunction

  function automatic logic [MASK_BITS-1:0] bit_at(input logic [PLW-1:0] kk);
    bit_at = (int'(kk) < MASK_BITS) ? (MASK_BITS'(1) << kk) : '0;
  endfunction

  // Memories
  logic [BW-1:0]        pat_mem [MAX_PATTERN];
  logic [BW-1:0]        win_mem [WDEPTH];
  logic [MASK_BITS-1:0] big_mem [BDEPTH];
  logic [MASK_BITS-1:0] lcm_mem [ALPHABET];

  logic [BW-1:0]        pat_q_r, win_q_r;
  logic [MASK_BITS-1:0] big_q_r, lcm_q_r;

  // Pattern and text state
  logic                     loading_r;
  logic [PLW-1:0]           plen_r, m1_r, m1w_r;
  logic [WAW-1:0]           wptr_r;
  logic [POSITION_BITS-1:0] tpos_r, nwe_r;
  logic                     closed_r;

  // Build state
  logic [ALPHABET-1:0]  seen_r;
  logic [PLW-1:0]       end_r, beg_r, k_r;
  logic [FCW-1:0]       f_r;
  logic [BW-1:0]        prev_r;
  logic                 b_done_r;
  logic [BAW-1:0]       clr_r;
  logic [BAW-1:0]       rmw_ba_r;
  logic                 rmw_be_r;
  logic [AW-1:0]        rmw_la_r;
  logic                 rmw_le_r;
  logic [MASK_BITS-1:0] rmw_v_r;
  logic [MASK_BITS-1:0] final_r;

  // Evaluation state
  logic [BW-1:0]        c_r, n_r;
  logic [MASK_BITS-1:0] d_r;
  logic [PLW-1:0]       ek_r, l_r, skip_r, i_r;
  logic                 hit_r;

  logic                 out_valid_r;
  logic [fbm_pkg::MATCH_W-1:0] out_pos_r;
  logic                 out_set;

  // Accept-side decode
  logic                     acc_pat, acc_txt;
  logic [PLW-1:0]           plen_eff, r_len;
  logic                     closed_eff;
  logic [POSITION_BITS-1:0] nwe_eff, pos_eff, j_plus_r;
  logic                     eval_go;

  assign acc_pat    = cmd.accept && (in_func == fbm_pkg::FUNC_PATTERN);
  assign acc_txt    = cmd.accept && (in_func == fbm_pkg::FUNC_TEXT);
  assign plen_eff   = loading_r ? plen_r : '0;
  assign r_len      = plen_r - m1_r;
  assign closed_eff = in_is_first_text ? 1'b0 : closed_r;
  assign nwe_eff    = in_is_first_text
                      ? ((m1_r != '0) ? POSITION_BITS'(m1_r - PLW'(1)) : '0)
                      : nwe_r;
  assign pos_eff    = in_is_first_text ? '0 : tpos_r;
  assign j_plus_r   = nwe_eff + POSITION_BITS'(r_len);
  assign eval_go    = !closed_eff && !loading_r && (m1_r != '0) && (j_plus_r == pos_eff);

  // Read addresses
  logic [PLW-1:0] pat_ra, win_d, win_ra_w;
  logic [BAW-1:0] big_ra;
  logic [AW-1:0]  lcm_ra;

  always_comb begin
    case (cmd.op)
      fbm_pkg::OP_F_RD: pat_ra = end_r;
      fbm_pkg::OP_B_RD: pat_ra = m1w_r - PLW'(1) - end_r;
      fbm_pkg::OP_R_RD: pat_ra = m1_r + i_r;
      default:          pat_ra = '0;
    endcase
    case (cmd.op)
      fbm_pkg::OP_E_RDW: win_d = r_len + ek_r;
      fbm_pkg::OP_R_RD:  win_d = r_len - PLW'(1) - i_r;
      default:           win_d = r_len;
    endcase
    if (cmd.op == fbm_pkg::OP_E_RDT) begin
      big_ra = bidx(fold_lut[c_r], fold_lut[win_q_r]);
      lcm_ra = fold_lut[c_r];
    end else begin
      big_ra = rmw_ba_r;
      lcm_ra = rmw_la_r;
    end
  end

  // win(d) sits d entries behind the newest byte
  assign win_ra_w = PLW'(wptr_r) - PLW'(1) - win_d;

  // Write ports
  logic                 pat_we, win_we, big_we, lcm_we;
  logic [BAW-1:0]       big_wa;
  logic [AW-1:0]        lcm_wa;
  logic [MASK_BITS-1:0] big_wd, lcm_wd;
  logic                 clr_op;

  assign clr_op = (cmd.op == fbm_pkg::OP_CLR);
  assign pat_we = acc_pat && (plen_eff < PLW'(MAX_PATTERN));
  assign win_we = acc_txt && !closed_eff;
  assign big_we = clr_op || ((cmd.op == fbm_pkg::OP_RMW_WR) && rmw_be_r);
  assign lcm_we = (clr_op && (clr_r < BAW'(ALPHABET)))
                  || ((cmd.op == fbm_pkg::OP_RMW_WR) && rmw_le_r);
  assign big_wa = clr_op ? clr_r : rmw_ba_r;
  assign lcm_wa = clr_op ? AW'(clr_r) : rmw_la_r;
  assign big_wd = clr_op ? '0 : (big_q_r | rmw_v_r);
  assign lcm_wd = clr_op ? '0 : (lcm_q_r | rmw_v_r);

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[PAW'(plen_eff)] <= in_byte_value;
    pat_q_r <= pat_mem[PAW'(pat_ra)];
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[wptr_r] <= in_byte_value;
    win_q_r <= win_mem[WAW'(win_ra_w)];
  end

  always_ff @(posedge clk) begin
    if (big_we) big_mem[big_wa] <= big_wd;
    big_q_r <= big_mem[big_ra];
  end

  always_ff @(posedge clk) begin
    if (lcm_we) lcm_mem[lcm_wa] <= lcm_wd;
    lcm_q_r <= lcm_mem[lcm_ra];
  end

  // Build and scan arithmetic
  logic [AW-1:0]        pq_f;
  logic                 pq_seen;
  logic [PLW-1:0]       end_inc, k_nxt, l_upd;
  logic [MASK_BITS-1:0] d_and, d_sum;
  logic                 d_fin, e_fin_hit, e_stop;

  assign pq_f      = fold_lut[pat_q_r];
  assign pq_seen   = seen_r[pq_f];
  assign end_inc   = end_r + PLW'(1);
  assign d_and     = d_r & big_q_r;
  assign d_sum     = d_and + (d_and & lcm_q_r);
  assign k_nxt     = ek_r + PLW'(1);
  assign d_fin     = |(d_sum & final_r);
  assign e_fin_hit = d_fin && (k_nxt == m1_r);
  assign l_upd     = (d_fin && !e_fin_hit) ? k_nxt : l_r;
  assign e_stop    = e_fin_hit || (d_sum == '0) || (k_nxt >= m1_r);

  always_comb begin
    st.acc_build = (in_func == fbm_pkg::FUNC_PATTERN) && in_is_last_pattern;
    st.acc_eval  = (in_func == fbm_pkg::FUNC_TEXT) && eval_go;
    st.clr_last  = (clr_r == BAW'(BDEPTH - 1));
    st.f_end     = (end_r == plen_r);
    st.f_stop    = pq_seen && (f_r == F_LAST);
    st.m1_zero   = (end_r == '0);
    st.b_done    = b_done_r;
    st.m1_one    = (m1_r == PLW'(1));
    st.e_stop    = e_stop;
    st.r_done    = !hit_r || (i_r == r_len);
    st.out_wait  = hit_r && out_valid_r && out_stall;
  end

  assign out_set = (cmd.op == fbm_pkg::OP_OUT) && !st.out_wait && hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r   <= 1'b0;
      plen_r      <= '0;
      m1_r        <= '0;
      m1w_r       <= '0;
      wptr_r      <= '0;
      tpos_r      <= '0;
      nwe_r       <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      b_done_r    <= 1'b0;
      clr_r       <= '0;
    end else begin
      if (out_set) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        fbm_pkg::OP_IDLE: begin
          if (acc_pat) begin
            loading_r <= 1'b1;
            if (!loading_r) m1_r <= '0;
            plen_r <= pat_we ? plen_eff + PLW'(1) : plen_eff;
            if (in_is_last_pattern) begin
              clr_r   <= '0;
              final_r <= '0;
            end
          end else if (acc_txt) begin
            if (in_is_first_text) begin
              nwe_r <= nwe_eff;
            end
            if (!closed_eff) begin
              wptr_r   <= wptr_r + WAW'(1);
              tpos_r   <= pos_eff + POSITION_BITS'(1);
              closed_r <= in_is_last_text;
            end
            hit_r <= 1'b0;
            i_r   <= '0;
          end
        end
        fbm_pkg::OP_CLR: begin
          clr_r  <= clr_r + BAW'(1);
          seen_r <= '0;
          end_r  <= '0;
          f_r    <= '0;
        end
        fbm_pkg::OP_F_USE: begin
          if (!pq_seen) begin
            seen_r[pq_f] <= 1'b1;
            end_r        <= end_inc;
          end else if (f_r != F_LAST) begin
            f_r    <= f_r + FCW'(1);
            seen_r <= '0;
          end
        end
        fbm_pkg::OP_F_FIN: begin
          m1w_r    <= end_r;
          end_r    <= '0;
          beg_r    <= '0;
          k_r      <= '0;
          seen_r   <= '0;
          b_done_r <= 1'b0;
        end
        fbm_pkg::OP_B_USE: begin
          rmw_ba_r <= bidx(fold_lut[prev_r], pq_f);
          rmw_v_r  <= bit_at(k_r);
          if (!pq_seen) begin
            seen_r[pq_f] <= 1'b1;
            end_r        <= end_inc;
            prev_r       <= pat_q_r;
            rmw_be_r     <= (end_r != beg_r);
            if (end_inc == m1w_r) begin
              b_done_r <= 1'b1;
              if (end_inc > beg_r + PLW'(1)) begin
                // last factor of two or more: mark its second-to-last char
                rmw_la_r <= fold_lut[prev_r];
                rmw_le_r <= 1'b1;
                final_r  <= bit_at(k_r) << 1;
              end else begin
                rmw_le_r <= 1'b0;
                final_r  <= bit_at(k_r);
              end
            end else begin
              rmw_le_r <= 1'b0;
            end
          end else begin
            // factor closes on a repeated char; it is read again next round
            rmw_be_r <= 1'b1;
            rmw_la_r <= fold_lut[prev_r];
            rmw_le_r <= 1'b1;
            beg_r    <= end_r;
            k_r      <= k_r + PLW'(1);
            seen_r   <= '0;
          end
        end
        fbm_pkg::OP_BDONE: begin
          m1_r      <= m1w_r;
          tpos_r    <= '0;
          nwe_r     <= (m1w_r != '0) ? POSITION_BITS'(m1w_r - PLW'(1)) : '0;
          closed_r  <= 1'b0;
          loading_r <= 1'b0;
        end
        fbm_pkg::OP_E_INIT: begin
          l_r  <= (win_q_r == pat_q_r) ? PLW'(1) : '0;
          c_r  <= win_q_r;
          d_r  <= '1;
          ek_r <= PLW'(1);
          if (m1_r == PLW'(1)) begin
            hit_r  <= (win_q_r == pat_q_r);
            skip_r <= PLW'(1);
          end
        end
        fbm_pkg::OP_E_RDT: n_r <= win_q_r;
        fbm_pkg::OP_E_UPD: begin
          d_r  <= d_sum;
          c_r  <= n_r;
          ek_r <= k_nxt;
          l_r  <= l_upd;
          if (e_fin_hit) hit_r <= 1'b1;
          if (e_stop) skip_r <= m1_r - l_upd;
        end
        fbm_pkg::OP_R_CMP: begin
          if (pat_q_r != win_q_r) hit_r <= 1'b0;
          i_r <= i_r + PLW'(1);
        end
        fbm_pkg::OP_OUT: begin
          if (!st.out_wait) begin
            nwe_r <= nwe_r + POSITION_BITS'(skip_r);
            if (hit_r) begin
              out_pos_r <= fbm_pkg::MATCH_W'(nwe_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match_position = out_pos_r;

endmodule

// ===== hw/rtl/factorized_bndm_matcher_top.sv =====
// Text word without evaluation: taken in the idle state. Evaluated window: initial reads,
// then a table read and update per scanned byte and a compare per remainder byte.
// Last pattern word: the bigram table is cleared entry by entry (ALPHABET*ALPHABET
// entries), then the tables are built from the prefix bytes and factor boundaries.
// Reset (rst_n low, synchronous) empties the pattern, the text state and the output;
// tables are rebuilt on every pattern load, so their contents are not reset.
`timescale 1ns / 1ps

module factorized_bndm_matcher_top #(
  parameter int MAX_PATTERN   = fbm_pkg::MAX_PATTERN_DEF,
  parameter int ALPHABET      = fbm_pkg::ALPHABET_DEF,
  parameter int MASK_BITS     = fbm_pkg::MASK_BITS_DEF,
  parameter int POSITION_BITS = fbm_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words: pattern bytes, then text bytes
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [fbm_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic                        in_is_last_pattern,
  input  logic                        in_is_first_text,
  input  logic                        in_is_last_text,
  // result words: end positions of matched prefixes
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fbm_pkg::MATCH_W-1:0] out_match_position
);

  fbm_pkg::cmd_t cmd;
  fbm_pkg::st_t  st;

  // Sequencer: accepts a word only in its idle state, steps the build and scan
  fbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: pattern store, text window ring, bigram and last-char tables,
  // scan registers and the output register that holds a result until taken
  fbm_dp #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET      (ALPHABET),
    .MASK_BITS     (MASK_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_func            (in_func),
    .in_byte_value      (in_byte_value),
    .in_is_last_pattern (in_is_last_pattern),
    .in_is_first_text   (in_is_first_text),
    .in_is_last_text    (in_is_last_text),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match_position (out_match_position)
  );

endmodule
